@@ rtl/rbw_pkg.sv @@
// shared types and constants of the rollback input window
`timescale 1ns / 1ps
package rbw_pkg;
   localparam int WINDOW_DEPTH = 128;
   localparam int SLOT_BITS = $clog2(WINDOW_DEPTH);

   typedef struct packed {
      logic [15:0] loc;
      logic [15:0] rem;
      logic        lok;
      logic        rok;
      logic        rgs;
      logic        wrg;
   } record_type;

   typedef enum logic [2:0] {
      MODE_SET_LOCAL  = 3'd0,
      MODE_CONFIRM    = 3'd1,
      MODE_PREDICT    = 3'd2,
      MODE_READ       = 3'd3,
      MODE_FIND       = 3'd4,
      MODE_CLEAR      = 3'd5,
      MODE_SPARE_A    = 3'd6,
      MODE_SPARE_B    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SCAN,
      ST_DONE
   } state_type;
endpackage

@@ rtl/rbw_cell.sv @@
// one window slot of the record chain
`timescale 1ns / 1ps
module rbw_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  rbw_pkg::record_type rec_in,
   output rbw_pkg::record_type rec_out
);
   rbw_pkg::record_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else if (adv) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;
endmodule

@@ rtl/rollback_input_window.sv @@
// top level: record chain, window bounds and operation sequencer
`timescale 1ns / 1ps
// channel  | ports                      | handshake
// request  | req_mode/frame/value       | start high while busy low
// response | rsp_* fields               | rsp_valid, one cycle, no stall
// config   | csr_wdata                  | csr_we
// an item rotates the chain once through the head cell, preceded by up to
// WINDOW_DEPTH zero-fill shifts when the window advances or is cleared. reset is
// synchronous and clears the whole chain at once.
// busy stays high until the response word has been shown.
module rollback_input_window (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [30:0] req_frame,
   input  logic [15:0] req_value,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [15:0] rsp_local_word,
   output logic [15:0] rsp_remote_word,
   output logic        rsp_local_ok,
   output logic        rsp_remote_ok,
   output logic        rsp_remote_guessed,
   output logic        rsp_guess_wrong,
   output logic        rsp_mismatch,
   output logic signed [31:0] rsp_found_frame,
   output logic [30:0] rsp_oldest_frame,
   output logic signed [31:0] rsp_newest_local_frame,
   output logic signed [31:0] rsp_latest_remote_frame,
   output logic [7:0]  rsp_predicted_count
);
   localparam int D = rbw_pkg::WINDOW_DEPTH;
   localparam int SB = rbw_pkg::SLOT_BITS;

   rbw_pkg::state_type state_ff, state_in;
   rbw_pkg::mode_type  mode_ff;
   logic [30:0] frame_ff, base_ff;
   logic [15:0] value_ff, neutral_ff;
   logic signed [31:0] nloc_ff, nrem_ff, found_ff;
   logic        hit_ff;
   logic [SB-1:0] tgt_ff;
   logic [SB:0] step_ff, len_ff;
   logic [7:0]  cnt_ff;
   logic        mis_ff;
   rbw_pkg::record_type out_rec_ff;

   rbw_pkg::record_type chain [D];
   rbw_pkg::record_type tail_in, head, mrec;
   logic adv;

   genvar gi;
   generate
      for (gi = 0; gi < D; gi++) begin : g_cell
         rbw_pkg::record_type nxt;
         if (gi == D - 1) begin : g_tail
            assign nxt = tail_in;
         end else begin : g_mid
            assign nxt = chain[gi+1];
         end
         rbw_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .adv    (adv),
            .rec_in (nxt),
            .rec_out(chain[gi])
         );
      end
   endgenerate

   // accept-time decode
   logic        accept, wr_mode, adv_win, ovr, hit_new, is_clear;
   logic [30:0] d_old, base_new, base_sel, d_new;
   logic [SB:0] len_new;
   logic signed [32:0] f_s;

   always_comb begin
      accept   = start && (state_ff == rbw_pkg::ST_IDLE);
      wr_mode  = req_mode <= 3'(rbw_pkg::MODE_PREDICT);
      is_clear = req_mode == 3'(rbw_pkg::MODE_CLEAR);
      d_old    = req_frame - base_ff;
      adv_win  = wr_mode && (req_frame >= base_ff) && (d_old >= 31'(D));
      ovr      = d_old >= 31'(2 * D - 1);
      len_new  = '0;
      base_new = base_ff;
      if (is_clear) begin
         len_new  = (SB+1)'(D);
         base_new = '0;
      end else if (adv_win) begin
         len_new  = ovr ? (SB+1)'(D) : (SB+1)'(d_old - 31'(D - 1));
         base_new = req_frame - 31'(D - 1);
      end
      base_sel = base_new;
      d_new    = req_frame - base_sel;
      hit_new  = (req_frame >= base_sel) && (d_new < 31'(D));
      f_s      = $signed({2'b00, req_frame});
   end

   // scan datapath
   logic [31:0] fk;
   logic signed [32:0] fk_s;
   logic at_tgt, in_cnt, in_find;

   always_comb begin
      head   = chain[0];
      fk     = {1'b0, base_ff} + 32'(step_ff[SB-1:0]);
      fk_s   = $signed({1'b0, fk});
      at_tgt = hit_ff && (step_ff[SB-1:0] == tgt_ff);
      mrec   = head;
      if (at_tgt) begin
         unique case (mode_ff)
            rbw_pkg::MODE_SET_LOCAL: begin
               mrec.loc = value_ff;
               mrec.lok = 1'b1;
            end
            rbw_pkg::MODE_CONFIRM: begin
               if (head.rgs && head.rem != value_ff) mrec.wrg = 1'b1;
               mrec.rem = value_ff;
               mrec.rok = 1'b1;
               mrec.rgs = 1'b0;
            end
            rbw_pkg::MODE_PREDICT: begin
               if (!head.rok) begin
                  mrec.rem = value_ff;
                  mrec.rgs = 1'b1;
                  mrec.wrg = 1'b0;
               end
            end
            default: mrec = head;
         endcase
      end
      in_cnt  = (fk_s >= 33'(nrem_ff) + 33'sd1) && (fk_s <= 33'(nloc_ff));
      in_find = (fk_s >= $signed({2'b00, frame_ff})) && (fk_s <= 33'(nloc_ff));
      tail_in = (state_ff == rbw_pkg::ST_SCAN) ? mrec : '0;
      adv     = (state_ff == rbw_pkg::ST_SHIFT) || (state_ff == rbw_pkg::ST_SCAN);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbw_pkg::ST_IDLE: begin
            if (accept) state_in = (len_new != '0) ? rbw_pkg::ST_SHIFT : rbw_pkg::ST_SCAN;
         end
         rbw_pkg::ST_SHIFT: begin
            if (step_ff == len_ff - 1'b1) state_in = rbw_pkg::ST_SCAN;
         end
         rbw_pkg::ST_SCAN: begin
            if (step_ff == (SB+1)'(D - 1)) state_in = rbw_pkg::ST_DONE;
         end
         rbw_pkg::ST_DONE: state_in = rbw_pkg::ST_IDLE;
         default: state_in = rbw_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rbw_pkg::ST_IDLE;
         base_ff    <= '0;
         nloc_ff    <= -32'sd1;
         nrem_ff    <= -32'sd1;
         neutral_ff <= '0;
         step_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) neutral_ff <= csr_wdata;
         if (state_ff != state_in) begin
            step_ff <= '0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
         if (accept) begin
            base_ff <= base_new;
            if (is_clear) begin
               nloc_ff <= -32'sd1;
               nrem_ff <= -32'sd1;
            end else if (hit_new) begin
               if (req_mode == 3'(rbw_pkg::MODE_SET_LOCAL) && f_s > 33'(nloc_ff))
                  nloc_ff <= {1'b0, req_frame};
               if (req_mode == 3'(rbw_pkg::MODE_CONFIRM) && f_s > 33'(nrem_ff))
                  nrem_ff <= {1'b0, req_frame};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= rbw_pkg::mode_type'(req_mode);
         frame_ff <= req_frame;
         value_ff <= req_value;
         hit_ff   <= hit_new;
         tgt_ff   <= d_new[SB-1:0];
         len_ff   <= len_new;
         cnt_ff   <= '0;
         mis_ff   <= 1'b0;
         found_ff <= -32'sd1;
         out_rec_ff <= '0;
      end else if (state_ff == rbw_pkg::ST_SCAN) begin
         if (at_tgt) begin
            out_rec_ff <= mrec;
            mis_ff <= (mode_ff == rbw_pkg::MODE_CONFIRM) && head.rgs && (head.rem != value_ff);
         end
         if (in_cnt && mrec.rgs && !mrec.rok && cnt_ff != 8'hFF) cnt_ff <= cnt_ff + 1'b1;
         if (mode_ff == rbw_pkg::MODE_FIND && found_ff == -32'sd1 && in_find && mrec.wrg)
            found_ff <= $signed(fk);
      end
   end

   assign busy               = state_ff != rbw_pkg::ST_IDLE;
   assign rsp_valid          = state_ff == rbw_pkg::ST_DONE;
   assign rsp_local_word     = hit_ff ? out_rec_ff.loc : neutral_ff;
   assign rsp_remote_word    = hit_ff ? out_rec_ff.rem : neutral_ff;
   assign rsp_local_ok       = hit_ff && out_rec_ff.lok;
   assign rsp_remote_ok      = hit_ff && out_rec_ff.rok;
   assign rsp_remote_guessed = hit_ff && out_rec_ff.rgs;
   assign rsp_guess_wrong    = hit_ff && out_rec_ff.wrg;
   assign rsp_mismatch       = mis_ff;
   assign rsp_found_frame    = found_ff;
   assign rsp_oldest_frame   = base_ff;
   assign rsp_newest_local_frame  = nloc_ff;
   assign rsp_latest_remote_frame = nrem_ff;
   assign rsp_predicted_count     = cnt_ff;
endmodule
